>>> src/rpd_pkg.sv
// recurrence plot pair distance: shared widths, codes and state type
// no dependencies; imported by rpd_isqrt and the top level
`default_nettype none

package rpd_pkg;

	// fixed field and register widths
	localparam int SAMPLE_W   = 16;
	localparam int IDX_W      = 10;
	localparam int LEN_W_CFG  = 11;
	localparam int DIM_W_CFG  = 5;
	localparam int DLY_W      = 10;
	localparam int THR_W      = 20;
	localparam int NORM_W     = 2;
	localparam int DIST_W     = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// stream packing
	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_TUSER_W = 2;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// parameter defaults
	localparam int SERIES_DEPTH_DEF  = 1024;
	localparam int MAX_DIMENSION_DEF = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SERIES_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMBED_DIM     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EMBED_DELAY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE     = 3'd4;

	// norm codes, any other code acts as supremum
	localparam logic [NORM_W-1:0] NORM_MANHATTAN = 2'd0;
	localparam logic [NORM_W-1:0] NORM_EUCLIDEAN = 2'd1;
	localparam logic [NORM_W-1:0] NORM_SUPREMUM  = 2'd2;

	// request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_PAIR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_ROOT,
		ST_DONE
	} rpd_state_t;

endpackage

`default_nettype wire

>>> src/rpd_ram.sv
// generic synchronous ram: one write port, two registered read ports
// no dependencies
`default_nettype none

module rpd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr0,
	input  wire logic [$clog2(DEPTH)-1:0] raddr1,
	output logic      [WIDTH-1:0]         rdata0,
	output logic      [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

`default_nettype wire

>>> src/rpd_isqrt.sv
// iterative integer square root, one result bit per cycle
// depends on rpd_pkg
`default_nettype none

module rpd_isqrt
	import rpd_pkg::*;
#(
	parameter int IN_W = 36
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [IN_W-1:0]       radicand,
	output logic                       done,
	output logic      [(IN_W+1)/2-1:0] root
);

	localparam int RT_W  = (IN_W + 1) / 2;
	localparam int NW    = 2 * RT_W;
	localparam int RW    = RT_W + 2;
	localparam int CNT_W = $clog2(RT_W + 1);

	logic [NW-1:0]    n_q;
	logic [RW-1:0]    rem_q;
	logic [RT_W-1:0]  root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [RW+1:0] rem_next;
	logic [RW+1:0] trial;
	logic          fits;

	always_comb begin
		rem_next = {rem_q, n_q[NW-1 -: 2]};
		trial    = (RW+2)'({root_q, 2'b01});
		fits     = rem_next >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(RT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= NW'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 2;
			if (fits) begin
				rem_q  <= RW'(rem_next - trial);
				root_q <= {root_q[RT_W-2:0], 1'b1};
			end else begin
				rem_q  <= RW'(rem_next);
				root_q <= {root_q[RT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

>>> src/recurrence_plot_pair_distance_top.sv
// recurrence plot pair distance engine, top level
// depends on rpd_pkg, rpd_ram, rpd_isqrt
`default_nettype none

// Load transactions write one signed sample into the series memory and give no result.
// A pair transaction reads both vectors from the series memory, one component pair per
// cycle over its two read ports, through a three-stage difference, square and accumulate
// pipeline. The euclidean norm then adds a bit-serial square root. A pair with an index
// outside the vector count finishes with the error flag set. One item is worked on at a
// time; a finished result waits in the output register while the next item is taken.
module recurrence_plot_pair_distance_top
	import rpd_pkg::*;
#(
	parameter int SERIES_DEPTH  = SERIES_DEPTH_DEF,
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// index_a, index_b, sample, zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// req_type
	input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// distance, zero pad
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
	// recurrent, pair_error
	output logic      [OUT_TUSER_W-1:0] m_axis_tuser
);

	localparam int AW     = $clog2(SERIES_DEPTH);
	localparam int LEN_W  = $clog2(SERIES_DEPTH + 1);
	localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
	localparam int SPAN_W = DIM_W + DLY_W;
	localparam int CW     = (SPAN_W > LEN_W) ? SPAN_W : LEN_W;
	localparam int ACC_W  = 2 * SAMPLE_W + DIM_W;
	localparam int RT_W   = (ACC_W + 1) / 2;
	localparam int SAT_W  = (ACC_W > DIST_W) ? ACC_W : DIST_W;
	localparam int TW     = (ACC_W > 2 * THR_W) ? ACC_W : 2 * THR_W;

	// configuration
	logic [LEN_W_CFG-1:0] series_length_q;
	logic [DIM_W_CFG-1:0] embed_dimension_q;
	logic [DLY_W-1:0]     embed_delay_q;
	logic [THR_W-1:0]     threshold_q;
	logic [NORM_W-1:0]    norm_mode_q;
	logic [2*THR_W-1:0]   thr_sq_q;

	// input fields
	logic                req_type;
	logic [IDX_W-1:0]    index_a;
	logic [IDX_W-1:0]    index_b;
	logic [SAMPLE_W-1:0] sample;

	// derived configuration
	logic [LEN_W-1:0]  len_eff;
	logic [DIM_W-1:0]  dim_eff;
	logic [DLY_W-1:0]  dly_eff;
	logic [SPAN_W-1:0] span;
	logic [CW-1:0]     vec_count;
	logic              idx_err;
	logic              is_euclid;
	logic              is_manhattan;

	// control
	rpd_state_t    state_q, state_d;
	logic          root_start;
	logic          root_done;
	logic          in_accept;
	logic          issue;
	logic          pipe_empty;
	logic          out_load;
	logic [DIM_W-1:0] steps_q;
	logic [AW-1:0] addr_a_q;
	logic [AW-1:0] addr_b_q;
	logic          err_q;
	logic          rec_q;

	// datapath
	logic                  ram_we;
	logic [SAMPLE_W-1:0]   rdata_a;
	logic [SAMPLE_W-1:0]   rdata_b;
	logic                  rd_s1;
	logic                  vld_s2;
	logic                  vld_s3;
	logic signed [SAMPLE_W:0] diff;
	logic [SAMPLE_W-1:0]   mag;
	logic [SAMPLE_W-1:0]   mag_s2;
	logic [SAMPLE_W-1:0]   mag_s3;
	logic [2*SAMPLE_W-1:0] sq_s3;
	logic [ACC_W-1:0]      acc_q;
	logic [RT_W-1:0]       root;
	logic [SAT_W-1:0]      dist_src;
	logic [DIST_W-1:0]     dist_sat;

	// output register
	logic              out_valid_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_rec_q;
	logic              out_err_q;

	assign req_type = s_axis_tuser[0];
	assign index_a  = s_axis_tdata[IDX_W-1:0];
	assign index_b  = s_axis_tdata[2*IDX_W-1:IDX_W];
	assign sample   = s_axis_tdata[2*IDX_W+SAMPLE_W-1:2*IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_length_q   <= '0;
			embed_dimension_q <= DIM_W_CFG'(1);
			embed_delay_q     <= DLY_W'(1);
			threshold_q       <= '0;
			norm_mode_q       <= NORM_MANHATTAN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SERIES_LENGTH: series_length_q   <= cfg_data[LEN_W_CFG-1:0];
				REG_EMBED_DIM:     embed_dimension_q <= cfg_data[DIM_W_CFG-1:0];
				REG_EMBED_DELAY:   embed_delay_q     <= cfg_data[DLY_W-1:0];
				REG_THRESHOLD:     threshold_q       <= cfg_data[THR_W-1:0];
				REG_NORM_MODE:     norm_mode_q       <= cfg_data[NORM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		thr_sq_q <= threshold_q * threshold_q;
	end

	always_comb begin
		if (32'(series_length_q) > SERIES_DEPTH) begin
			len_eff = LEN_W'(SERIES_DEPTH);
		end else begin
			len_eff = LEN_W'(series_length_q);
		end
		if (embed_dimension_q == '0) begin
			dim_eff = DIM_W'(1);
		end else if (32'(embed_dimension_q) > MAX_DIMENSION) begin
			dim_eff = DIM_W'(MAX_DIMENSION);
		end else begin
			dim_eff = DIM_W'(embed_dimension_q);
		end
		dly_eff = (embed_delay_q == '0) ? DLY_W'(1) : embed_delay_q;
		span    = SPAN_W'(dim_eff - 1'b1) * SPAN_W'(dly_eff);
		if (CW'(len_eff) > CW'(span)) begin
			vec_count = CW'(len_eff) - CW'(span);
		end else begin
			vec_count = '0;
		end
		idx_err      = (CW'(index_a) >= vec_count) || (CW'(index_b) >= vec_count);
		is_euclid    = norm_mode_q == NORM_EUCLIDEAN;
		is_manhattan = norm_mode_q == NORM_MANHATTAN;
	end

	assign pipe_empty = !rd_s1 && !vld_s2 && !vld_s3;

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		issue         = 1'b0;
		root_start    = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && req_type == REQ_PAIR) begin
					state_d = idx_err ? ST_DONE : ST_READ;
				end
			end
			ST_READ: begin
				issue = 1'b1;
				if (steps_q == DIM_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (pipe_empty) begin
					if (is_euclid) begin
						root_start = 1'b1;
						state_d    = ST_ROOT;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_ROOT: begin
				if (root_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign ram_we    = in_accept && req_type == REQ_LOAD && 32'(index_a) < SERIES_DEPTH;

	rpd_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(SERIES_DEPTH)
	) u_series (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(index_a)),
		.wdata (sample),
		.raddr0(addr_a_q),
		.raddr1(addr_b_q),
		.rdata0(rdata_a),
		.rdata1(rdata_b)
	);

	rpd_isqrt #(
		.IN_W(ACC_W)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.radicand(acc_q),
		.done    (root_done),
		.root    (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_s1   <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= issue;
			vld_s2  <= rd_s1;
			vld_s3  <= vld_s2;
		end
	end

	// per-pair control payload
	always_ff @(posedge clk) begin
		if (in_accept && req_type == REQ_PAIR) begin
			addr_a_q <= AW'(index_a);
			addr_b_q <= AW'(index_b);
			steps_q  <= dim_eff;
			err_q    <= idx_err;
		end else if (issue) begin
			addr_a_q <= addr_a_q + AW'(dly_eff);
			addr_b_q <= addr_b_q + AW'(dly_eff);
			steps_q  <= steps_q - 1'b1;
		end
	end

	// difference, square, accumulate
	always_comb begin
		diff = $signed({rdata_a[SAMPLE_W-1], rdata_a}) - $signed({rdata_b[SAMPLE_W-1], rdata_b});
		if (diff < 0) begin
			mag = SAMPLE_W'(-diff);
		end else begin
			mag = SAMPLE_W'(diff);
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= mag;
		mag_s3 <= mag_s2;
		sq_s3  <= mag_s2 * mag_s2;
		if (in_accept) begin
			acc_q <= '0;
		end else if (vld_s3) begin
			if (is_manhattan) begin
				acc_q <= acc_q + ACC_W'(mag_s3);
			end else if (is_euclid) begin
				acc_q <= acc_q + ACC_W'(sq_s3);
			end else if (ACC_W'(mag_s3) > acc_q) begin
				acc_q <= ACC_W'(mag_s3);
			end
		end
		if (state_q == ST_DRAIN && pipe_empty) begin
			if (is_euclid) begin
				rec_q <= TW'(acc_q) <= TW'(thr_sq_q);
			end else begin
				rec_q <= TW'(acc_q) <= TW'(threshold_q);
			end
		end
	end

	always_comb begin
		dist_src = is_euclid ? SAT_W'(root) : SAT_W'(acc_q);
		if (dist_src > SAT_W'(DIST_MAX)) begin
			dist_sat = DIST_MAX;
		end else begin
			dist_sat = DIST_W'(dist_src);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_dist_q <= err_q ? '0 : dist_sat;
			out_rec_q  <= err_q ? 1'b0 : rec_q;
			out_err_q  <= err_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_dist_q);
	assign m_axis_tuser  = {out_err_q, out_rec_q};

endmodule

`default_nettype wire
